FILE: hw/rtl/psf_pkg.sv
// Shared types and constants of the pendulum state feedback step core.
// No dependencies; every other file imports this package.
`default_nettype none

package psf_pkg;

	// Encoder counts per pendulum revolution (default of the top-level parameter)
	localparam int PSF_COUNTS_PER_REV = 4000;

	// Entries in the queue between front and back
	localparam int PSF_QUEUE_DEPTH = 2;

	// Reset value of the drive limit: 12.0 in Q16.16
	localparam logic [30:0] PSF_DRIVE_LIMIT_RESET = 31'd786432;

	// Full-scale PWM duty
	localparam logic [7:0] PSF_DUTY_FULL = 8'd255;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_GAIN_ANGLE          = 3'd0,
		REG_GAIN_WHEEL_POSITION = 3'd1,
		REG_GAIN_ANGLE_RATE     = 3'd2,
		REG_GAIN_WHEEL_RATE     = 3'd3,
		REG_DRIVE_LIMIT         = 3'd4
	} psf_reg_t;

	// Feedback terms that travel alongside the angle wrap
	typedef struct packed {
		logic               en;
		logic signed [31:0] wheel;
		logic signed [32:0] dp;
		logic signed [32:0] dw;
	} psf_terms_t;

	// One classified request as stored in the queue
	typedef struct packed {
		logic       neg;
		logic       big;
		logic [31:0] mag;
		psf_terms_t terms;
	} psf_entry_t;

	// Gains and limit seen by the drive datapath
	typedef struct packed {
		logic signed [31:0] gain_angle;
		logic signed [31:0] gain_wheel_position;
		logic signed [31:0] gain_angle_rate;
		logic signed [31:0] gain_wheel_rate;
		logic        [30:0] drive_limit;
	} psf_cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/psf_front.sv
// Front end: accepts encoder requests, keeps previous counts and the enable flag,
// forms the count differences and classifies the pendulum count. Uses psf_pkg.
`default_nettype none

module psf_front import psf_pkg::*; #(
	parameter int COUNTS_PER_REV = PSF_COUNTS_PER_REV
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic signed [31:0] pendulum_count,
	input  wire logic signed [31:0] wheel_count,
	input  wire logic               toggle_enable,
	input  wire logic               full,
	output logic                    push,
	output psf_entry_t              entry
);

	localparam logic [31:0] REV_V = 32'(COUNTS_PER_REV);

	logic signed [31:0] prev_pend_q;
	logic signed [31:0] prev_wheel_q;
	logic               en_q;
	logic               en_next;
	logic [31:0]        pend_neg;

	assign push     = in_valid && !full;
	assign en_next  = en_q ^ toggle_enable;
	assign pend_neg = 32'(-pendulum_count);

	// Classify and difference the request
	always_comb begin
		entry.neg       = pendulum_count[31];
		entry.mag       = pendulum_count[31] ? pend_neg : pendulum_count;
		entry.big       = entry.mag > REV_V;
		entry.terms.en  = en_next;
		entry.terms.wheel = wheel_count;
		entry.terms.dp  = 33'(pendulum_count) - 33'(prev_pend_q);
		entry.terms.dw  = 33'(wheel_count) - 33'(prev_wheel_q);
	end

	// Advance tick state on every accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pend_q  <= '0;
			prev_wheel_q <= '0;
			en_q         <= 1'b0;
		end else if (push) begin
			prev_pend_q  <= pendulum_count;
			prev_wheel_q <= wheel_count;
			en_q         <= en_next;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/psf_fifo.sv
// Short queue of classified requests between the front end and the datapath.
// Uses psf_pkg for the entry type.
`default_nettype none

module psf_fifo import psf_pkg::*; #(
	parameter int DEPTH = PSF_QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire psf_entry_t wdata,
	input  wire logic       pop,
	output psf_entry_t      rdata,
	output logic            full,
	output logic            empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);
	localparam logic [CNTW-1:0] DEPTH_V = CNTW'(DEPTH);
	localparam logic [AW-1:0] LAST_V = AW'(DEPTH - 1);

	psf_entry_t        mem_q [DEPTH];
	logic [AW-1:0]     wptr_q;
	logic [AW-1:0]     rptr_q;
	logic [CNTW-1:0]   count_q;

	assign full  = count_q == DEPTH_V;
	assign empty = count_q == '0;
	assign rdata = mem_q[rptr_q];

	// Store incoming entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == LAST_V) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == LAST_V) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/psf_wrap.sv
// Angle wrap pipeline: truncated remainder by the revolution count through a
// reciprocal multiply with one correction, then the half-revolution offset. Uses psf_pkg.
`default_nettype none

module psf_wrap import psf_pkg::*; #(
	parameter int COUNTS_PER_REV = PSF_COUNTS_PER_REV,
	parameter int CW = $clog2(COUNTS_PER_REV + 1) + 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire logic                 in_valid,
	input  wire psf_entry_t           entry,
	output logic                      out_valid,
	output logic signed [CW-1:0]      wrapped,
	output psf_terms_t                terms
);

	localparam logic [63:0] RECIP64 = (64'd1 << 32) / 64'(COUNTS_PER_REV);
	localparam logic [31:0] RECIP_V = RECIP64[31:0];
	localparam logic [31:0] REV32_V = 32'(COUNTS_PER_REV);
	localparam logic [CW-1:0] REV_V = CW'(COUNTS_PER_REV);
	localparam logic [CW-1:0] HALF_V = CW'(COUNTS_PER_REV / 2);

	logic                v_s1, v_s2, v_s3, v_s4;
	logic [31:0]         q_s1, qr_s2;
	logic [31:0]         mag_s1, mag_s2;
	logic [CW-1:0]       mag_s3, r_s3;
	logic                neg_s1, neg_s2, neg_s3;
	logic                big_s1, big_s2, big_s3;
	psf_terms_t          terms_s1, terms_s2, terms_s3, terms_s4;
	logic signed [CW-1:0] wrapped_s4;

	logic [63:0]         qprod;
	logic [31:0]         diff;
	logic [CW-1:0]       rr;
	logic [CW-1:0]       cm;
	logic signed [CW:0]  t;
	logic signed [CW:0]  t_neg;

	assign qprod = 64'(entry.mag) * 64'(RECIP_V);
	assign diff  = mag_s2 - qr_s2;

	// Correct the remainder, pick the reduced count and offset by half a turn
	always_comb begin
		rr    = (r_s3 >= REV_V) ? r_s3 - REV_V : r_s3;
		cm    = big_s3 ? rr : mag_s3;
		t     = $signed({1'b0, cm}) - $signed({1'b0, HALF_V});
		t_neg = -t;
	end

	// Advance the valid bits with the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Advance the payload with the pipeline
	always_ff @(posedge clk) begin
		if (adv) begin
			q_s1     <= qprod[63:32];
			mag_s1   <= entry.mag;
			neg_s1   <= entry.neg;
			big_s1   <= entry.big;
			terms_s1 <= entry.terms;

			qr_s2    <= q_s1 * REV32_V;
			mag_s2   <= mag_s1;
			neg_s2   <= neg_s1;
			big_s2   <= big_s1;
			terms_s2 <= terms_s1;

			r_s3     <= diff[CW-1:0];
			mag_s3   <= mag_s2[CW-1:0];
			neg_s3   <= neg_s2;
			big_s3   <= big_s2;
			terms_s3 <= terms_s2;

			if (cm == '0) begin
				wrapped_s4 <= '0;
			end else begin
				wrapped_s4 <= neg_s3 ? t_neg[CW-1:0] : t[CW-1:0];
			end
			terms_s4 <= terms_s3;
		end
	end

	assign out_valid = v_s4;
	assign wrapped   = wrapped_s4;
	assign terms     = terms_s4;

endmodule

`default_nettype wire

FILE: hw/rtl/psf_drive.sv
// Drive datapath: four gain products, exact sum, floor to Q16.16, saturation,
// enable gating and PWM duty split, ending in the output register. Uses psf_pkg.
`default_nettype none

module psf_drive import psf_pkg::*; #(
	parameter int COUNTS_PER_REV = PSF_COUNTS_PER_REV,
	parameter int CW = $clog2(COUNTS_PER_REV + 1) + 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire logic                 in_valid,
	input  wire logic signed [CW-1:0] wrapped,
	input  wire psf_terms_t           terms,
	input  wire psf_cfg_t             cfg,
	output logic                      out_valid,
	output logic signed [31:0]        drive_value,
	output logic [7:0]                forward_duty,
	output logic [7:0]                reverse_duty,
	output logic [11:0]               wrapped_angle,
	output logic                      saturated_flag
);

	logic v_s5, v_s6, v_s7, v_s8, v_q;
	logic en_s5, en_s6, en_s7;

	logic signed [64:0] p0_s5, p1_s5, p2_s5, p3_s5;
	logic signed [64:0] p0, p1, p2, p3;
	logic signed [65:0] sa_s6, sb_s6;
	logic signed [66:0] total;
	logic signed [50:0] u_s7;
	logic signed [31:0] drive_s8;
	logic               clip_s8;
	logic signed [CW-1:0] wr_s5, wr_s6, wr_s7, wr_s8;

	logic signed [50:0] lim;
	logic signed [50:0] lim_neg;
	logic signed [31:0] lim32;
	logic signed [31:0] drive_n;
	logic               clip_n;
	logic [31:0]        mag;
	logic [23:0]        scaled;
	logic [7:0]         duty;
	logic signed [31:0] wr_ext;

	// Form the four products
	always_comb begin
		p0 = cfg.gain_angle * wrapped;
		p1 = cfg.gain_wheel_position * terms.wheel;
		p2 = cfg.gain_angle_rate * terms.dp;
		p3 = cfg.gain_wheel_rate * terms.dw;
	end

	assign total = 67'(sa_s6) + 67'(sb_s6);

	// Saturate to the limit and gate by the enable flag
	always_comb begin
		lim     = $signed({20'b0, cfg.drive_limit});
		lim_neg = -lim;
		lim32   = $signed({1'b0, cfg.drive_limit});
		if (u_s7 > lim) begin
			drive_n = lim32;
			clip_n  = 1'b1;
		end else if (u_s7 < lim_neg) begin
			drive_n = -lim32;
			clip_n  = 1'b1;
		end else begin
			drive_n = u_s7[31:0];
			clip_n  = 1'b0;
		end
		if (!en_s7) begin
			drive_n = '0;
			clip_n  = 1'b0;
		end
	end

	// Scale the magnitude to an 8-bit duty, full scale at 1.0
	always_comb begin
		mag    = drive_s8[31] ? 32'(-drive_s8) : drive_s8;
		scaled = {mag[15:0], 8'b0} - {8'b0, mag[15:0]};
		duty   = (mag[31:16] != '0) ? PSF_DUTY_FULL : scaled[23:16];
		wr_ext = 32'(wr_s8);
	end

	// Advance the valid bits with the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_q  <= 1'b0;
		end else if (adv) begin
			v_s5 <= in_valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_q  <= v_s8;
		end
	end

	// Advance the payload with the pipeline
	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s5 <= p0;
			p1_s5 <= p1;
			p2_s5 <= p2;
			p3_s5 <= p3;
			en_s5 <= terms.en;
			wr_s5 <= wrapped;

			sa_s6 <= 66'(p0_s5) + 66'(p1_s5);
			sb_s6 <= 66'(p2_s5) + 66'(p3_s5);
			en_s6 <= en_s5;
			wr_s6 <= wr_s5;

			u_s7  <= total[66:16];
			en_s7 <= en_s6;
			wr_s7 <= wr_s6;

			drive_s8 <= drive_n;
			clip_s8  <= clip_n;
			wr_s8    <= wr_s7;

			drive_value    <= drive_s8;
			forward_duty   <= (!drive_s8[31] && drive_s8 != '0) ? duty : 8'd0;
			reverse_duty   <= drive_s8[31] ? duty : 8'd0;
			wrapped_angle  <= wr_ext[11:0];
			saturated_flag <= clip_s8;
		end
	end

	assign out_valid = v_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pendulum_state_feedback_step_core.sv
// Top level of the pendulum state feedback step core: configuration registers,
// front end, queue, angle wrap and drive datapath. Uses psf_pkg and all psf_* modules.
//
// One request per encoder tick; one result per request, in order. The core
// sustains one request per clock while the output side does not stall: the back
// end is a nine-stage pipeline (four stages of angle wrap; products, partial sums,
// floor and saturation; then the output register, which also forms the duty) that
// advances whenever the output register is empty or being taken. A two-entry
// queue sits between the front end and the pipeline, and in_stall is high only
// while that queue is full.
// The user must write gains and limit through cfg_we/cfg_index/cfg_wdata only
// while no request is in flight; the core does not enforce this. Writes to
// unused indexes are dropped.
`default_nettype none

module pendulum_state_feedback_step_core import psf_pkg::*; #(
	parameter int COUNTS_PER_REV = PSF_COUNTS_PER_REV
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] pendulum_count,
	input  wire logic signed [31:0] wheel_count,
	input  wire logic               toggle_enable,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      drive_value,
	output logic [7:0]              forward_duty,
	output logic [7:0]              reverse_duty,
	output logic [11:0]             wrapped_angle,
	output logic                    saturated_flag
);

	localparam int CW = $clog2(COUNTS_PER_REV + 1) + 1;

	psf_cfg_t             cfg_q;
	psf_entry_t           push_entry;
	psf_entry_t           pop_entry;
	logic                 push;
	logic                 pop;
	logic                 full;
	logic                 empty;
	logic                 adv;
	logic                 wrap_valid;
	logic signed [CW-1:0] wrapped;
	psf_terms_t           terms;
	logic signed [31:0]   lim32;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_angle          <= '0;
			cfg_q.gain_wheel_position <= '0;
			cfg_q.gain_angle_rate     <= '0;
			cfg_q.gain_wheel_rate     <= '0;
			cfg_q.drive_limit         <= PSF_DRIVE_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (psf_reg_t'(cfg_index))
				REG_GAIN_ANGLE:          cfg_q.gain_angle          <= cfg_wdata;
				REG_GAIN_WHEEL_POSITION: cfg_q.gain_wheel_position <= cfg_wdata;
				REG_GAIN_ANGLE_RATE:     cfg_q.gain_angle_rate     <= cfg_wdata;
				REG_GAIN_WHEEL_RATE:     cfg_q.gain_wheel_rate     <= cfg_wdata;
				REG_DRIVE_LIMIT:         cfg_q.drive_limit         <= cfg_wdata[30:0];
				default: begin
				end
			endcase
		end
	end

	// Move the whole back end together when the output can take a result
	assign adv      = !out_valid || !out_stall;
	assign pop      = adv && !empty;
	assign in_stall = full;

	psf_front #(
		.COUNTS_PER_REV(COUNTS_PER_REV)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.pendulum_count(pendulum_count),
		.wheel_count   (wheel_count),
		.toggle_enable (toggle_enable),
		.full          (full),
		.push          (push),
		.entry         (push_entry)
	);

	psf_fifo #(
		.DEPTH(PSF_QUEUE_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (push_entry),
		.pop   (pop),
		.rdata (pop_entry),
		.full  (full),
		.empty (empty)
	);

	psf_wrap #(
		.COUNTS_PER_REV(COUNTS_PER_REV),
		.CW            (CW)
	) u_wrap (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (!empty),
		.entry    (pop_entry),
		.out_valid(wrap_valid),
		.wrapped  (wrapped),
		.terms    (terms)
	);

	psf_drive #(
		.COUNTS_PER_REV(COUNTS_PER_REV),
		.CW            (CW)
	) u_drive (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_valid      (wrap_valid),
		.wrapped       (wrapped),
		.terms         (terms),
		.cfg           (cfg_q),
		.out_valid     (out_valid),
		.drive_value   (drive_value),
		.forward_duty  (forward_duty),
		.reverse_duty  (reverse_duty),
		.wrapped_angle (wrapped_angle),
		.saturated_flag(saturated_flag)
	);

	assign lim32 = $signed({1'b0, cfg_q.drive_limit});

	// A clipped result sits exactly on the limit
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated_flag |-> drive_value == lim32 || drive_value == -lim32)
		else $error("clipped drive is not at the limit");

	// Only one PWM channel is driven at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> forward_duty == 8'd0 || reverse_duty == 8'd0)
		else $error("both PWM channels driven");

	// Forward duty only for a positive drive
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && forward_duty != 8'd0 |-> !drive_value[31] && drive_value != 32'sd0)
		else $error("forward duty without positive drive");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for pendulum_state_feedback_step_core: directed and random encoder
// ticks under random idling, an in-bench drive predictor and in-order result checks.
// Depends on psf_pkg and the core RTL only.

module tb;
	import psf_pkg::*;

	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 90;
	localparam int HALF_REV    = PSF_COUNTS_PER_REV / 2;
	localparam int PHASE_TICKS = 78;
	localparam int MAX_REPORTS = 50;

	typedef struct {
		logic signed [31:0] pend;
		logic signed [31:0] wheel;
		logic               toggle;
	} tick_t;

	typedef struct {
		logic signed [31:0] drive;
		logic [7:0]         fwd;
		logic [7:0]         rev;
		logic [11:0]        angle;
		logic               sat;
	} drive_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] pendulum_count;
	logic signed [31:0] wheel_count;
	logic               toggle_enable;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] drive_value;
	logic [7:0]         forward_duty;
	logic [7:0]         reverse_duty;
	logic [11:0]        wrapped_angle;
	logic               saturated_flag;

	// Predictor copy of registers and state
	logic signed [31:0] k_angle, k_wheel_pos, k_angle_rate, k_wheel_rate;
	logic [30:0]        drive_lim;
	logic signed [31:0] last_pend, last_wheel;
	logic               fb_enabled;

	tick_t         pending_ticks[$];
	drive_result_t expected_drives[$];

	logic               tick_taken = 1'b0;
	int                 ticks_taken = 0;
	int                 results_checked = 0;
	int                 errors = 0;
	int                 idle_cycles = 0;
	int                 burst_left = 0;
	int                 gap_left = 0;
	int                 hold_left = 0;
	int                 long_holds = 0;
	int                 mode_left = 0;
	int                 stall_mode = 0;
	logic [7:0]         stall_pattern = 8'h00;
	logic signed [31:0] pend_walk = 0;
	logic signed [31:0] wheel_walk = 0;

	pendulum_state_feedback_step_core #(
		.COUNTS_PER_REV(PSF_COUNTS_PER_REV)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pendulum_count(pendulum_count),
		.wheel_count(wheel_count),
		.toggle_enable(toggle_enable),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.drive_value(drive_value),
		.forward_duty(forward_duty),
		.reverse_duty(reverse_duty),
		.wrapped_angle(wrapped_angle),
		.saturated_flag(saturated_flag)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Work out the result of one tick and advance the predictor state
	function automatic drive_result_t predict_drive(tick_t t);
		longint             c, wrapped, dp, dw, mag;
		logic signed [67:0] acc, u, lim;
		drive_result_t      r;
		if (t.toggle)
			fb_enabled = !fb_enabled;
		c = t.pend;
		if (c > PSF_COUNTS_PER_REV || c < -PSF_COUNTS_PER_REV)
			c = c % PSF_COUNTS_PER_REV;
		if (c > 0)
			wrapped = c - HALF_REV;
		else if (c < 0)
			wrapped = c + HALF_REV;
		else
			wrapped = 0;
		dp = longint'(t.pend) - longint'(last_pend);
		dw = longint'(t.wheel) - longint'(last_wheel);
		last_pend = t.pend;
		last_wheel = t.wheel;
		// Sum the four products exactly, then floor to Q16.16
		acc = longint'(k_angle) * wrapped;
		acc = acc + longint'(k_wheel_pos) * longint'(t.wheel);
		acc = acc + longint'(k_angle_rate) * dp;
		acc = acc + longint'(k_wheel_rate) * dw;
		u = acc >>> 16;
		lim = {37'd0, drive_lim};
		r.sat = 1'b0;
		if (u > lim) begin
			u = lim;
			r.sat = 1'b1;
		end else if (u < -lim) begin
			u = -lim;
			r.sat = 1'b1;
		end
		if (!fb_enabled) begin
			u = 0;
			r.sat = 1'b0;
		end
		mag = (u < 0) ? -u : u;
		if (mag >= 65536)
			mag = PSF_DUTY_FULL;
		else
			mag = (mag * PSF_DUTY_FULL) / 65536;
		r.drive = u[31:0];
		r.fwd = (u > 0) ? mag[7:0] : 8'd0;
		r.rev = (u < 0) ? mag[7:0] : 8'd0;
		r.angle = wrapped[11:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("mismatch on %s at result %0d: got %0h, want %0h",
				what, results_checked, got, want);
	endtask

	// Write one register at the falling edge and mirror it in the predictor
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_GAIN_ANGLE:          k_angle = data;
			REG_GAIN_WHEEL_POSITION: k_wheel_pos = data;
			REG_GAIN_ANGLE_RATE:     k_angle_rate = data;
			REG_GAIN_WHEEL_RATE:     k_wheel_rate = data;
			REG_DRIVE_LIMIT:         drive_lim = data[30:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_gains(input int style, input logic [31:0] limit_word);
		logic [31:0] g [4];
		for (int i = 0; i < 4; i++) begin
			case (style)
				0: g[i] = int'($urandom_range(0, 4096)) - 2048;
				1: g[i] = int'($urandom_range(0, 1 << 18)) - (1 << 17);
				2: g[i] = $urandom();
				default: begin
					case ($urandom_range(0, 3))
						0: g[i] = 32'h8000_0000;
						1: g[i] = 32'h7fff_ffff;
						2: g[i] = 32'h0000_0000;
						default: g[i] = 32'hffff_ffff;
					endcase
				end
			endcase
		end
		write_reg(REG_GAIN_ANGLE, g[0]);
		write_reg(REG_GAIN_WHEEL_POSITION, g[1]);
		write_reg(REG_GAIN_ANGLE_RATE, g[2]);
		write_reg(REG_GAIN_WHEEL_RATE, g[3]);
		write_reg(REG_DRIVE_LIMIT, limit_word);
	endtask

	task automatic add_tick(input logic [31:0] pend, input logic [31:0] wheel,
			input logic toggle);
		tick_t t;
		t.pend = pend;
		t.wheel = wheel;
		t.toggle = toggle;
		pending_ticks.push_back(t);
	endtask

	// Mostly a slow walk of the count, with jumps to wrap boundaries and extremes
	task automatic step_count(inout logic signed [31:0] walk);
		int k, j;
		k = $urandom_range(0, 6);
		j = $urandom_range(0, 2);
		case ($urandom_range(0, 9))
			0: walk = $urandom();
			1: walk = PSF_COUNTS_PER_REV * (k - 3) + (j - 1);
			2: walk = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			3: walk = int'($urandom_range(0, 6 * PSF_COUNTS_PER_REV)) - 3 * PSF_COUNTS_PER_REV;
			default: walk = walk + (int'($urandom_range(0, 80)) - 40);
		endcase
	endtask

	task automatic push_random_ticks(input int count);
		for (int i = 0; i < count; i++) begin
			step_count(pend_walk);
			step_count(wheel_walk);
			add_tick(pend_walk, wheel_walk, $urandom_range(0, 15) == 0);
		end
	endtask

	task automatic wait_idle();
		while (pending_ticks.size() != 0 || expected_drives.size() != 0)
			@(posedge clk);
	endtask

	// Stimulus: reset, directed ticks, then random phases under several settings
	initial begin
		logic [31:0] limit_word;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		pendulum_count = '0;
		wheel_count = '0;
		toggle_enable = 1'b0;
		out_stall = 1'b0;
		k_angle = '0;
		k_wheel_pos = '0;
		k_angle_rate = '0;
		k_wheel_rate = '0;
		drive_lim = PSF_DRIVE_LIMIT_RESET;
		last_pend = '0;
		last_wheel = '0;
		fb_enabled = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset drive limit
		write_reg(REG_GAIN_ANGLE, 32'd2097152);
		write_reg(REG_GAIN_WHEEL_POSITION, 32'hffff_fffd);
		write_reg(REG_GAIN_ANGLE_RATE, 32'd16384);
		write_reg(REG_GAIN_WHEEL_RATE, 32'hffff_f000);
		add_tick(32'd0, 32'd0, 1'b1);
		add_tick(32'd1, 32'd0, 1'b0);
		add_tick(-32'sd1, 32'd0, 1'b0);
		add_tick(32'd2000, 32'd0, 1'b0);
		add_tick(-32'sd2000, 32'd0, 1'b0);
		add_tick(32'd4000, 32'd0, 1'b0);
		add_tick(-32'sd4000, 32'd0, 1'b0);
		add_tick(32'd4001, 32'd0, 1'b0);
		add_tick(-32'sd4001, 32'd0, 1'b0);
		add_tick(32'd8000, 32'd0, 1'b0);
		add_tick(-32'sd12000, 32'd0, 1'b0);
		add_tick(32'h7fff_ffff, 32'd0, 1'b0);
		add_tick(32'h8000_0000, 32'd0, 1'b0);
		add_tick(32'd0, 32'h7fff_ffff, 1'b0);
		add_tick(32'd0, 32'h8000_0000, 1'b0);
		add_tick(32'd3, 32'd0, 1'b0);
		add_tick(32'd1234, 32'd99, 1'b1);
		add_tick(-32'sd777, 32'd5, 1'b0);
		add_tick(32'h5555_5555, 32'haaaa_aaaa, 1'b1);
		add_tick(-32'sd2001, -32'sd1, 1'b0);
		wait_idle();

		// Writes to indexes past the register list must change nothing
		for (int i = REG_DRIVE_LIMIT + 1; i < (1 << $bits(cfg_index)); i++)
			write_reg(3'(i), $urandom());

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: limit_word = 32'd65536;
				1: limit_word = 32'hffff_ffff;
				2: limit_word = 32'd0;
				3: limit_word = 32'd65535;
				4: limit_word = $urandom();
				5: limit_word = 32'h8000_0001;
				6: limit_word = 32'd786432;
				default: limit_word = $urandom_range(0, 1 << 22);
			endcase
			load_gains(ph % 4, limit_word);
			push_random_ticks(PHASE_TICKS);
			wait_idle();
		end

		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Request driver: bursts of random length separated by random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !tick_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_ticks.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				pendulum_count <= pending_ticks[0].pend;
				wheel_count <= pending_ticks[0].wheel;
				toggle_enable <= pending_ticks[0].toggle;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
				end
			end
		end
	end

	// Result stall: a stall mode chosen at random and changed at regular intervals, plus two long hold-offs
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (hold_left == 0 && long_holds < 2 && ticks_taken >= (long_holds + 1) * 200
					&& pending_ticks.size() > 40) begin
				hold_left = HOLD_CYCLES;
				long_holds++;
			end
			if (mode_left == 0) begin
				mode_left = 128;
				stall_mode = $urandom_range(0, 3);
				stall_pattern = $urandom();
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 9) < 6);
					default: begin
						out_stall <= stall_pattern[0];
						stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
					end
				endcase
			end
		end
	end

	// Take requests into the predictor, check results in order, watch for a hang
	always @(posedge clk) begin : check_results
		tick_t         req;
		drive_result_t want;
		logic          result_taken;
		if (!arst_n) begin
			tick_taken = 1'b0;
		end else begin
			tick_taken = in_valid && !in_stall;
			result_taken = out_valid && !out_stall;
			if (tick_taken) begin
				req.pend = pendulum_count;
				req.wheel = wheel_count;
				req.toggle = toggle_enable;
				expected_drives.push_back(predict_drive(req));
				void'(pending_ticks.pop_front());
				ticks_taken++;
			end
			if (result_taken) begin
				if (expected_drives.size() == 0) begin
					report_mismatch("result with none pending", drive_value, 32'd0);
				end else begin
					want = expected_drives.pop_front();
					if (drive_value !== want.drive)
						report_mismatch("drive_value", drive_value, want.drive);
					if (forward_duty !== want.fwd)
						report_mismatch("forward_duty", forward_duty, want.fwd);
					if (reverse_duty !== want.rev)
						report_mismatch("reverse_duty", reverse_duty, want.rev);
					if (wrapped_angle !== want.angle)
						report_mismatch("wrapped_angle", wrapped_angle, want.angle);
					if (saturated_flag !== want.sat)
						report_mismatch("saturated_flag", saturated_flag, want.sat);
				end
				results_checked++;
			end
			if (tick_taken || result_taken
					|| (pending_ticks.size() == 0 && expected_drives.size() == 0))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

endmodule
